>>> src/mfcd_pkg.sv
package mfcd_pkg;

  localparam int MAX_FRAME_BYTES = 256;
  localparam int MAX_ENTRIES     = 27;

  localparam int CNT_W  = 9;   // byte count, saturates one past the store depth
  localparam int ADDR_W = 8;   // frame store address

  localparam logic [7:0] START_MARK = 8'hDF;
  localparam logic [7:0] END_MARK   = 8'hEF;

  localparam logic [CNT_W-1:0] MIN_FRAME_RESET = 9'd22;
  localparam logic [CNT_W-1:0] SHORTEST        = 9'd9;

  // opcodes
  localparam logic [7:0] OP_ENTRIES = 8'd1;
  localparam logic [7:0] OP_ACK     = 8'd2;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TOO_SHORT = 3'd1;
  localparam logic [2:0] ST_BAD_MARK  = 3'd2;
  localparam logic [2:0] ST_BAD_CKSUM = 3'd3;
  localparam logic [2:0] ST_OVERRUN   = 3'd4;
  localparam logic [2:0] ST_TOO_LONG  = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  opcode;
    logic        is_entry;
    logic [4:0]  entry_index;
    logic [7:0]  store_number;
    logic [31:0] start_position;
    logic [31:0] end_position;
    logic        send_ack;
    logic        ack_seen;
    logic        last;
  } result_t;

  // closing status result of a chunk, entry fields cleared
  function automatic result_t make_status(logic [2:0] st, logic [7:0] op,
                                          logic ack, logic seen);
    result_t r;
    r = '0;
    r.status   = st;
    r.opcode   = op;
    r.send_ack = ack;
    r.ack_seen = seen;
    r.last     = 1'b1;
    return r;
  endfunction

endpackage

>>> src/marker_framed_command_deframer.sv
// A byte without chunk_end is taken and gives no result. After the closing transfer the chunk is
// length checked (a failure is the one result); else the chunk is scanned in the frame store and
// a marker, checksum or overrun failure is reported, or one result per storage entry goes out before
// the final ok status. Throughput: one byte per cycle inside a chunk while busy is low;
// busy stays high for the end walk, which reads the frame store one byte a cycle.
// Reset (rst, synchronous): idle, byte count cleared, min_frame_bytes 22; results never stall.
module marker_framed_command_deframer
  import mfcd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // byte input, command style
  input  logic             start,
  output logic             busy,
  input  in_item_t         item,
  // min_frame_bytes write channel
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data,
  // result strobe
  output logic             result_valid,
  output result_t          result
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,  // collecting bytes
    S_CHECK  = 6'b000010,  // length checks
    S_SCAN   = 6'b000100,  // marker / checksum pass over the whole chunk
    S_DECIDE = 6'b001000,  // pick status, start entry pass
    S_ENTRY  = 6'b010000,  // stream out storage entries
    S_FINAL  = 6'b100000   // closing ok status
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;      // bytes in current chunk
  logic [CNT_W-1:0]  count_inc;
  logic [CNT_W-1:0]  n;          // length of closed chunk
  logic [CNT_W-1:0]  min_bytes;

  // frame store and its read pipeline
  logic [7:0]        mem [MAX_FRAME_BYTES];
  logic [7:0]        rd_data;
  logic [CNT_W-1:0]  ptr;        // next address to read
  logic [CNT_W-1:0]  ptr_end;    // one past last address of the pass
  logic              issue;
  logic              rv;         // rd_data holds a byte of the pass
  logic [CNT_W-1:0]  ridx;       // its address

  // scan results
  logic              bad_mark;
  logic [7:0]        xsum;
  logic [7:0]        cksum;
  logic [7:0]        op;
  logic [7:0]        cnt;

  // entry assembly
  logic [3:0]        k;          // byte within entry
  logic [4:0]        j;          // entry number
  logic [7:0]        sn;
  logic [31:0]       sp;
  logic [31:0]       ep;

  logic [11:0]       cnt9;       // 9 * entry count

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign count_inc = (count <= CNT_W'(MAX_FRAME_BYTES)) ? count + 1'b1 : count;
  assign cnt9      = {1'b0, cnt, 3'b000} + {4'b0000, cnt};

  assign issue = ((state == S_SCAN) || (state == S_ENTRY)) && (ptr < ptr_end);

  // frame store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && start && (count < CNT_W'(MAX_FRAME_BYTES))) begin
      mem[count[ADDR_W-1:0]] <= item.data_byte;
    end
    rd_data <= mem[ptr[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      min_bytes    <= MIN_FRAME_RESET;
      result_valid <= 1'b0;
      rv           <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      rv           <= issue;
      ridx         <= ptr;
      if (issue) begin
        ptr <= ptr + 1'b1;
      end
      if (cfg_valid) begin
        min_bytes <= cfg_data;
      end

      case (state)
        S_IDLE: begin
          if (start) begin
            if (item.chunk_end) begin
              n     <= count_inc;
              count <= '0;
              state <= S_CHECK;
            end else begin
              count <= count_inc;
            end
          end
        end

        S_CHECK: begin
          if (n > CNT_W'(MAX_FRAME_BYTES)) begin
            result       <= make_status(ST_TOO_LONG, 8'h00, 1'b0, 1'b0);
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end else if ((n < min_bytes) || (n < SHORTEST)) begin
            result       <= make_status(ST_TOO_SHORT, 8'h00, 1'b0, 1'b0);
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end else begin
            ptr      <= '0;
            ptr_end  <= n;
            bad_mark <= 1'b0;
            xsum     <= '0;
            state    <= S_SCAN;
          end
        end

        S_SCAN: begin
          if (rv) begin
            // first four bytes start marker, last four end marker
            if ((ridx < 9'd4) && (rd_data != START_MARK)) begin
              bad_mark <= 1'b1;
            end
            if ((ridx >= n - 9'd4) && (rd_data != END_MARK)) begin
              bad_mark <= 1'b1;
            end
            // payload before its checksum byte
            if ((ridx >= 9'd4) && (ridx <= n - 9'd6)) begin
              xsum <= xsum ^ rd_data;
            end
            if (ridx == n - 9'd5) begin
              cksum <= rd_data;
            end
            if (ridx == 9'd4) begin
              op <= rd_data;
            end
            if (ridx == 9'd7) begin
              cnt <= rd_data;
            end
            if (ridx == n - 9'd1) begin
              state <= S_DECIDE;
            end
          end
        end

        S_DECIDE: begin
          if (bad_mark) begin
            result       <= make_status(ST_BAD_MARK, 8'h00, 1'b0, 1'b0);
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end else if (xsum != cksum) begin
            result       <= make_status(ST_BAD_CKSUM, op, 1'b0, 1'b0);
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end else if (op == OP_ENTRIES) begin
            // payload must hold opcode, count byte, entries and checksum
            if ((n < 9'd13) || (cnt > 8'(MAX_ENTRIES)) ||
                ((cnt9 + 12'd13) > {3'b000, n})) begin
              result       <= make_status(ST_OVERRUN, op, 1'b0, 1'b0);
              result_valid <= 1'b1;
              state        <= S_IDLE;
            end else if (cnt == 8'd0) begin
              state <= S_FINAL;
            end else begin
              ptr     <= 9'd8;
              ptr_end <= 9'd8 + cnt9[CNT_W-1:0];
              k       <= '0;
              j       <= '0;
              state   <= S_ENTRY;
            end
          end else begin
            state <= S_FINAL;
          end
        end

        S_ENTRY: begin
          if (rv) begin
            k <= (k == 4'd8) ? 4'd0 : k + 1'b1;
            if (k == 4'd0) begin
              sn <= rd_data;
            end else if (k <= 4'd4) begin
              sp <= {rd_data, sp[31:8]};
            end else if (k <= 4'd7) begin
              ep <= {rd_data, ep[31:8]};
            end else begin
              result.status         <= ST_OK;
              result.opcode         <= op;
              result.is_entry       <= 1'b1;
              result.entry_index    <= j;
              result.store_number   <= sn;
              result.start_position <= sp;
              result.end_position   <= {rd_data, ep[31:8]};
              result.send_ack       <= 1'b0;
              result.ack_seen       <= 1'b0;
              result.last           <= 1'b0;
              result_valid          <= 1'b1;
              j                     <= j + 1'b1;
              if (j == cnt[4:0] - 5'd1) begin
                state <= S_FINAL;
              end
            end
          end
        end

        S_FINAL: begin
          result       <= make_status(ST_OK, op, 1'b1, (op == OP_ACK));
          result_valid <= 1'b1;
          state        <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
